// ===== rtl/record_stream_deframer_macros.svh =====
// Assertion macros shared by the record stream deframer RTL
`ifndef RECORD_STREAM_DEFRAMER_MACROS_SVH
`define RECORD_STREAM_DEFRAMER_MACROS_SVH

// check a condition at every clock edge out of reset
`define RSD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// check a consequence in the cycle after an antecedent
`define RSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rsd_pkg.sv =====
// Types and constants of the record stream deframer
package rsd_pkg;

  localparam int unsigned HC_W = 5;

  localparam logic [HC_W-1:0] TYPE_POS    = 5'd0;
  localparam logic [HC_W-1:0] STREAM_LAST = 5'd4;
  localparam logic [HC_W-1:0] SEQ_LAST    = 5'd12;
  localparam logic [HC_W-1:0] TS_LAST     = 5'd20;
  localparam logic [HC_W-1:0] HDR_LAST    = 5'd24;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_RECORD  = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TRUNC   = 2'd1,
    ST_PARTIAL = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]  record_type;
    logic [31:0] source_id;
    logic [63:0] sequence_number;
    logic [63:0] stamp_ns;
    logic [31:0] payload_length;
  } hdr_t;

endpackage

// ===== rtl/rsd_if.sv =====
// Valid/ready channel interfaces for the input and result words
interface rsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_buffer;
  logic       consumer_stop;

  modport source(output valid, data_byte, has_byte, end_of_buffer, consumer_stop,
                 input ready);
  modport sink(input valid, data_byte, has_byte, end_of_buffer, consumer_stop,
               output ready);
endinterface

interface rsd_out_if import rsd_pkg::*; ();
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [7:0]  record_type;
  logic [31:0] source_id;
  logic [63:0] sequence_number;
  logic [63:0] stamp_ns;
  logic [31:0] payload_length;
  logic [7:0]  payload_byte;
  logic        payload_end;
  status_t     status;
  logic        last;

  modport source(output valid, kind, record_type, source_id, sequence_number,
                 stamp_ns, payload_length, payload_byte, payload_end, status, last,
                 input ready);
  modport sink(input valid, kind, record_type, source_id, sequence_number,
               stamp_ns, payload_length, payload_byte, payload_end, status, last,
               output ready);
endinterface

// ===== rtl/record_stream_deframer.sv =====
// Record stream deframer top level: splits a byte stream into length-prefixed records
//
// One input word carries at most one buffer byte plus end-of-buffer and
// consumer-stop flags. Each record is a 25-byte big-endian header (type,
// stream id, sequence, timestamp, payload length) followed by the payload.
// Payload bytes come out as they arrive; a record-complete word carrying the
// header follows the last payload byte, or the header itself when the length
// is zero; an end-of-buffer word gives a status (ok, truncated payload,
// trailing partial header) and returns the parser to the start of a buffer.
// An input word is parsed in the cycle it is accepted and its results land in
// one result register that hands out one result word per cycle while the
// output is ready. A word that yields zero or one result is taken every cycle
// while the output is ready; a word that yields two or three results (last
// payload byte, record complete, status) holds the input while that register
// drains. The first result is valid in the cycle after the word is accepted.
`include "record_stream_deframer_macros.svh"

module record_stream_deframer import rsd_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  rsd_in_if.sink      in_chan,
  rsd_out_if.source   out_chan
);

  // parser state
  logic [HC_W-1:0] header_count_r, header_count_nxt;
  hdr_t            held_r, held_nxt;
  logic [31:0]     payload_left_r, payload_left_nxt;
  logic            in_payload_r, in_payload_nxt;
  logic            stopped_r, stopped_nxt;

  // result register
  logic            pend_pay_r, pend_rec_r, pend_stat_r;
  logic            pend_pay_nxt, pend_rec_nxt, pend_stat_nxt;
  hdr_t            snap_r;
  logic [7:0]      pbyte_r;
  logic            pend_r;
  status_t         status_r;

  logic            stop_eff, take, in_fire, out_fire, out_valid_w, single;
  logic            new_pay, new_end, new_rec, new_stat;
  status_t         new_st;
  logic [1:0]      pend_cnt;
  logic [7:0]      b;
  logic            eob_fire, at_start;

  assign b           = in_chan.data_byte;
  assign out_valid_w = pend_pay_r | pend_rec_r | pend_stat_r;
  assign pend_cnt    = {1'b0, pend_pay_r} + {1'b0, pend_rec_r} + {1'b0, pend_stat_r};
  assign single      = (pend_cnt == 2'd1);
  assign out_fire    = out_valid_w && out_chan.ready;
  assign in_chan.ready = !out_valid_w || (out_chan.ready && single);
  assign in_fire     = in_chan.valid && in_chan.ready;
  assign eob_fire    = in_fire && in_chan.end_of_buffer;
  assign at_start    = !in_payload_r && !stopped_r && (header_count_r == '0);

  always_comb begin
    stop_eff         = stopped_r | in_chan.consumer_stop;
    take             = !stop_eff && in_chan.has_byte;
    header_count_nxt = header_count_r;
    held_nxt         = held_r;
    payload_left_nxt = payload_left_r;
    in_payload_nxt   = in_payload_r;
    stopped_nxt      = stop_eff;
    new_pay          = 1'b0;
    new_end          = 1'b0;
    new_rec          = 1'b0;
    new_stat         = in_chan.end_of_buffer;
    new_st           = ST_OK;

    if (take) begin
      if (in_payload_r) begin
        new_pay = 1'b1;
        new_end = (payload_left_r <= 32'd1);
        if (new_end) begin
          payload_left_nxt = 32'd0;
          in_payload_nxt   = 1'b0;
          new_rec          = 1'b1;
        end else begin
          payload_left_nxt = payload_left_r - 32'd1;
        end
      end else begin
        priority if (header_count_r == TYPE_POS) begin
          held_nxt.record_type = b;
        end else if (header_count_r <= STREAM_LAST) begin
          held_nxt.source_id = {held_r.source_id[23:0], b};
        end else if (header_count_r <= SEQ_LAST) begin
          held_nxt.sequence_number = {held_r.sequence_number[55:0], b};
        end else if (header_count_r <= TS_LAST) begin
          held_nxt.stamp_ns = {held_r.stamp_ns[55:0], b};
        end else begin
          held_nxt.payload_length = {held_r.payload_length[23:0], b};
        end
        if (header_count_r == HDR_LAST) begin
          header_count_nxt = '0;
          if (held_nxt.payload_length == 32'd0) begin
            new_rec = 1'b1;
          end else begin
            payload_left_nxt = held_nxt.payload_length;
            in_payload_nxt   = 1'b1;
          end
        end else begin
          header_count_nxt = header_count_r + 5'd1;
        end
      end
    end

    if (!stop_eff) begin
      if (in_payload_nxt) begin
        new_st = ST_TRUNC;
      end else if (header_count_nxt != '0) begin
        new_st = ST_PARTIAL;
      end
    end

    // return to start of buffer after the status
    if (in_chan.end_of_buffer) begin
      header_count_nxt = '0;
      payload_left_nxt = 32'd0;
      in_payload_nxt   = 1'b0;
      stopped_nxt      = 1'b0;
    end
  end

  always_comb begin
    pend_pay_nxt  = pend_pay_r;
    pend_rec_nxt  = pend_rec_r;
    pend_stat_nxt = pend_stat_r;
    if (out_fire) begin
      priority if (pend_pay_r) begin
        pend_pay_nxt = 1'b0;
      end else if (pend_rec_r) begin
        pend_rec_nxt = 1'b0;
      end else begin
        pend_stat_nxt = 1'b0;
      end
    end
    if (in_fire) begin
      pend_pay_nxt  = new_pay;
      pend_rec_nxt  = new_rec;
      pend_stat_nxt = new_stat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_count_r <= '0;
      held_r         <= '0;
      payload_left_r <= 32'd0;
      in_payload_r   <= 1'b0;
      stopped_r      <= 1'b0;
      pend_pay_r     <= 1'b0;
      pend_rec_r     <= 1'b0;
      pend_stat_r    <= 1'b0;
    end else begin
      pend_pay_r  <= pend_pay_nxt;
      pend_rec_r  <= pend_rec_nxt;
      pend_stat_r <= pend_stat_nxt;
      if (in_fire) begin
        header_count_r <= header_count_nxt;
        held_r         <= in_chan.end_of_buffer ? '0 : held_nxt;
        payload_left_r <= payload_left_nxt;
        in_payload_r   <= in_payload_nxt;
        stopped_r      <= stopped_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      snap_r   <= held_nxt;
      pbyte_r  <= b;
      pend_r   <= new_end;
      status_r <= new_st;
    end
  end

  always_comb begin
    out_chan.valid = out_valid_w;
    out_chan.last  = single;
    priority if (pend_pay_r) begin
      out_chan.kind = KIND_PAYLOAD;
    end else if (pend_rec_r) begin
      out_chan.kind = KIND_RECORD;
    end else begin
      out_chan.kind = KIND_STATUS;
    end
    out_chan.record_type     = (pend_pay_r | pend_rec_r) ? snap_r.record_type : 8'd0;
    out_chan.source_id       = (pend_pay_r | pend_rec_r) ? snap_r.source_id : 32'd0;
    out_chan.sequence_number = (pend_pay_r | pend_rec_r) ? snap_r.sequence_number : 64'd0;
    out_chan.stamp_ns        = (pend_pay_r | pend_rec_r) ? snap_r.stamp_ns : 64'd0;
    out_chan.payload_length  = (pend_pay_r | pend_rec_r) ? snap_r.payload_length : 32'd0;
    out_chan.payload_byte    = pend_pay_r ? pbyte_r : 8'd0;
    out_chan.payload_end     = pend_pay_r & pend_r;
    out_chan.status          = (pend_pay_r | pend_rec_r) ? ST_OK : status_r;
  end

  `RSD_ASSERT_ALWAYS(a_hc_range, header_count_r <= HDR_LAST, "header count out of range")
  `RSD_ASSERT_ALWAYS(a_pay_no_hdr, !in_payload_r || (header_count_r == '0), "payload mid-header")
  `RSD_ASSERT_ALWAYS(a_pay_left, !in_payload_r || (payload_left_r != 32'd0), "empty payload run")
  `RSD_ASSERT_NEXT(a_eob_reset, eob_fire, at_start, "state kept after end")
  `RSD_ASSERT_NEXT(a_drain, out_fire && single && !in_fire, !out_valid_w, "result repeated")

endmodule
